// ----- design/mrfd_pkg.sv -----
// package for the register frame decoder: payload types, constants, crc table
// no dependencies
package mrfd_pkg;

   localparam int RegCount = 12;
   localparam int FrameBytes = 2 * RegCount + 5;
   localparam int IdxW = 4;
   localparam logic [15:0] ValueOffset = 16'd10000;
   localparam logic [IdxW-1:0] SteamWord = 4'd10;
   localparam logic [IdxW-1:0] WaterWord = 4'd11;

   localparam logic [1:0] CSR_STEAM_DIV = 2'd0;
   localparam logic [1:0] CSR_WATER_DIV = 2'd1;
   localparam logic [1:0] CSR_DEV_TYPE = 2'd2;
   localparam logic [1:0] CSR_NO_DATA = 2'd3;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic [3:0]  reg_index;
      logic [15:0] reg_value;
      logic        data_valid;
      logic        run_last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_RECV,
      ST_READ,
      ST_DIV,
      ST_OUT
   } state_type;

   // start and operand interface of the divider
   typedef struct packed {
      logic        start;
      logic [16:0] dividend;
      logic [14:0] divisor;
   } div_req_type;

   function automatic logic [15:0] crc_table(input logic [7:0] idx);
      logic [15:0] c;
      c = {8'd0, idx};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] t;
      t = crc_table(crc[7:0] ^ b);
      return {8'd0, crc[15:8]} ^ t;
   endfunction

endpackage

// ----- design/modbus_register_frame_decoder_unit.sv -----
// register frame decoder: crc and length check, word store, converted results
// depends on mrfd_pkg, mrfd_ram, mrfd_div
//
// usage: response bytes enter on req_ one per transfer, frame_last on the final
// byte. a byte that is not last is accepted while req_ready is high and gives
// no result. the crc over all but the last two bytes and the byte count are
// kept in registers; data words are written into a 12 entry ram.
// on the last byte the unit emits 12 results on rsp_, reg_index 0 to 11,
// run_last on index 11. each word is read from the ram, words 10 and 11 may
// pass the serial divider, and the result waits in the output register.
// req_ready stays low until the last result has entered the output register;
// any receiver stall extends that.
// a stall on rsp_ready holds the current result; nothing is dropped.
// reset clears the frame state and loads the csr defaults; ram contents are
// undefined until a frame writes them.
module modbus_register_frame_decoder_unit import mrfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);
   state_type   state_ff, state_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [15:0] tail_ff, tail_in;
   logic [7:0]  hold_ff, hold_in;
   logic        ok_ff, ok_in;
   logic [3:0]  idx_ff, idx_in;
   logic [14:0] steam_ff, water_ff;
   logic [7:0]  dtype_ff;
   logic [15:0] nodata_ff;
   logic        ov_ff, ov_in;
   rsp_type     out_ff, out_in;

   logic        take;
   logic        wr_en;
   logic [3:0]  wr_addr, rd_addr;
   logic [15:0] rd_data;
   logic [16:0] diff;
   logic        need_div;
   div_req_type dreq;
   logic        dbusy;
   logic [15:0] dquo;
   logic [7:0]  off;
   logic        frame_ok;

   mrfd_ram #(.Width(16), .Depth(RegCount)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data({hold_ff, req_data.rx_byte}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   mrfd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .dreq    (dreq),
      .busy    (dbusy),
      .quotient(dquo)
   );

   assign req_ready = (state_ff == ST_RECV);
   assign take = req_valid && req_ready;
   assign off = cnt_ff - 8'd3;
   assign rd_addr = idx_ff;
   assign diff = {1'b0, rd_data} - {1'b0, ValueOffset};
   assign need_div = ((idx_ff == SteamWord) && (dtype_ff == 8'd1)) || (idx_ff == WaterWord);

   // byte path
   always_comb begin
      crc_in = crc_ff;
      tail_in = tail_ff;
      hold_in = hold_ff;
      cnt_in = cnt_ff;
      wr_en = 1'b0;
      wr_addr = off[4:1];
      frame_ok = 1'b0;
      if (take) begin
         if (cnt_ff >= 8'd2) begin
            crc_in = crc_feed(crc_ff, tail_ff[15:8]);
         end
         tail_in = {tail_ff[7:0], req_data.rx_byte};
         if (cnt_ff >= 8'd3) begin
            if (!off[0]) begin
               hold_in = req_data.rx_byte;
            end else if (off[7:1] < 7'(RegCount)) begin
               wr_en = 1'b1;
            end
         end
         if (cnt_ff != 8'd255) begin
            cnt_in = cnt_ff + 8'd1;
         end
         frame_ok = (cnt_in == 8'(FrameBytes)) && (tail_in == {crc_in[7:0], crc_in[15:8]});
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RECV: if (take && req_data.frame_last) state_in = ST_READ;
         ST_READ: if (!ov_ff) state_in = (ok_ff && need_div) ? ST_DIV : ST_OUT;
         ST_DIV: if (!dbusy) state_in = ST_OUT;
         ST_OUT: state_in = (idx_ff == 4'(RegCount - 1)) ? ST_RECV : ST_READ;
         default: state_in = ST_RECV;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      idx_in = idx_ff;
      ok_in = ok_ff;
      ov_in = ov_ff && !rsp_ready;
      out_in = out_ff;
      dreq.start = 1'b0;
      dreq.dividend = diff;
      dreq.divisor = (idx_ff == SteamWord) ? steam_ff : water_ff;
      unique case (state_ff)
         ST_RECV: begin
            idx_in = 4'd0;
            if (take) ok_in = frame_ok;
         end
         ST_READ: begin
            if (!ov_ff && ok_ff && need_div) dreq.start = 1'b1;
         end
         ST_DIV: ;
         ST_OUT: begin
            out_in.reg_index = idx_ff;
            out_in.data_valid = ok_ff;
            out_in.run_last = (idx_ff == 4'(RegCount - 1));
            if (!ok_ff) out_in.reg_value = nodata_ff;
            else if (need_div) out_in.reg_value = dquo;
            else out_in.reg_value = diff[15:0];
            ov_in = 1'b1;
            idx_in = idx_ff + 4'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RECV;
         crc_ff <= 16'hFFFF;
         cnt_ff <= 8'd0;
         tail_ff <= 16'd0;
         hold_ff <= 8'd0;
         ov_ff <= 1'b0;
         idx_ff <= 4'd0;
         ok_ff <= 1'b0;
         steam_ff <= 15'd1;
         water_ff <= 15'd1;
         dtype_ff <= 8'd1;
         nodata_ff <= 16'h8000;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         idx_ff <= idx_in;
         ok_ff <= ok_in;
         if (take && req_data.frame_last) begin
            crc_ff <= 16'hFFFF;
            cnt_ff <= 8'd0;
            tail_ff <= 16'd0;
            hold_ff <= 8'd0;
         end else begin
            crc_ff <= crc_in;
            cnt_ff <= cnt_in;
            tail_ff <= tail_in;
            hold_ff <= hold_in;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_STEAM_DIV: steam_ff <= csr_wr_data[14:0];
               CSR_WATER_DIV: water_ff <= csr_wr_data[14:0];
               CSR_DEV_TYPE: dtype_ff <= csr_wr_data[7:0];
               CSR_NO_DATA: nodata_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
      out_ff <= out_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;

   a_no_input_while_emitting: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RECV) |-> !req_ready)
      else $error("input accepted during emission");
   a_out_only_on_free_reg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> !ov_ff)
      else $error("output register overwritten");
   a_div_done_before_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && state_in == ST_OUT) |-> !dbusy)
      else $error("divider result used early");
endmodule

// ----- design/mrfd_ram.sv -----
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
module mrfd_ram #(
   parameter int Width = 16,
   parameter int Depth = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- design/mrfd_div.sv -----
// restoring signed divider, one quotient bit per cycle, truncating toward zero
// depends on mrfd_pkg
module mrfd_div import mrfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type dreq,
   output logic        busy,
   output logic [15:0] quotient
);
   logic [16:0] rem_ff, rem_in;
   logic [16:0] quo_ff, quo_in;
   logic [14:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [17:0] trial;
   logic [16:0] mag;
   logic [16:0] q_signed;

   always_comb begin
      mag = dreq.dividend[16] ? (~dreq.dividend + 17'd1) : dreq.dividend;
      trial = {rem_ff, quo_ff[16]} - {3'd0, dvs_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (dreq.start) begin
         rem_in = 17'd0;
         quo_in = mag;
         dvs_in = (dreq.divisor == 15'd0) ? 15'd1 : dreq.divisor;
         neg_in = dreq.dividend[16];
         cnt_in = 5'd17;
      end else if (cnt_ff != 5'd0) begin
         cnt_in = cnt_ff - 5'd1;
         if (!trial[17]) begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], quo_ff[16]};
            quo_in = {quo_ff[15:0], 1'b0};
         end
      end
      q_signed = neg_ff ? (~quo_ff + 17'd1) : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 5'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign busy = dreq.start || (cnt_ff != 5'd0);
   assign quotient = q_signed[15:0];
endmodule

// ----- tb/testbench.sv -----
// testbench for the register frame decoder: crc and length check, word conversion
// depends on mrfd_pkg and modbus_register_frame_decoder_unit
`timescale 1ns / 100ps

module testbench;
   import mrfd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wr_data;

   modbus_register_frame_decoder_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // predictor state
   logic [14:0] steam_div_q, water_div_q;
   logic [7:0]  dev_type_q;
   logic [15:0] no_data_q;
   logic [15:0] crc_q, tail_q;
   logic [7:0]  count_q, hold_q;
   logic [15:0] words_q [RegCount];

   rsp_type     pending_q [$];
   int          errors;
   int          byte_total;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function automatic logic [15:0] convert_word(input logic [15:0] w,
                                                input logic [14:0] d, input bit divide);
      int v, dv;
      v = int'(w) - 10000;
      if (divide) begin
         dv = (d == 0) ? 1 : int'(d);
         v = v / dv;
      end
      return v[15:0];
   endfunction

   task automatic predict_byte(input logic [7:0] b, input logic last);
      int pos, off;
      bit ok;
      rsp_type r;
      pos = count_q;
      if (pos >= 2) crc_q = crc_step(crc_q, tail_q[15:8]);
      tail_q = {tail_q[7:0], b};
      if (pos >= 3) begin
         off = pos - 3;
         if (off % 2 == 0) hold_q = b;
         else if (off / 2 < RegCount) words_q[off / 2] = {hold_q, b};
      end
      if (count_q < 255) count_q++;
      if (last) begin
         ok = (count_q == FrameBytes) && (tail_q == {crc_q[7:0], crc_q[15:8]});
         for (int k = 0; k < RegCount; k++) begin
            r.reg_index = k[3:0];
            if (!ok) r.reg_value = no_data_q;
            else if (k == 10) r.reg_value = convert_word(words_q[k], steam_div_q,
                                                         dev_type_q == 8'd1);
            else if (k == 11) r.reg_value = convert_word(words_q[k], water_div_q, 1'b1);
            else r.reg_value = convert_word(words_q[k], 15'd1, 1'b0);
            r.data_valid = ok;
            r.run_last = (k == RegCount - 1);
            pending_q.push_back(r);
         end
         crc_q = 16'hFFFF; count_q = 0; tail_q = 0; hold_q = 0;
      end
   endtask

   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 9);
      if (n < 5) n = 0;
      else if (n < 9) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 40);
      repeat (n) @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      idle_gap();
      req_valid = 1'b1;
      req_data = '{rx_byte: b, frame_last: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte(b, last);
      byte_total++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drain();
      while (pending_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_STEAM_DIV: steam_div_q = val[14:0];
         CSR_WATER_DIV: water_div_q = val[14:0];
         CSR_DEV_TYPE:  dev_type_q = val[7:0];
         CSR_NO_DATA:   no_data_q = val;
         default: ;
      endcase
   endtask

   // mode: 0 good, 1 bad crc, 2 short, 3 long
   task automatic send_frame(input int mode, input logic [15:0] fixed_word, input bit use_fixed);
      logic [7:0] bytes [$];
      logic [15:0] c, w;
      int n;
      bytes.push_back(8'($urandom));
      bytes.push_back(8'($urandom));
      bytes.push_back(8'($urandom));
      for (int i = 0; i < RegCount; i++) begin
         w = use_fixed ? fixed_word : 16'($urandom);
         if (!use_fixed && $urandom_range(0, 3) == 0) w = 16'($urandom_range(9000, 11000));
         bytes.push_back(w[15:8]);
         bytes.push_back(w[7:0]);
      end
      if (mode == 2) begin
         n = $urandom_range(1, 10);
         repeat (n) void'(bytes.pop_back());
      end
      if (mode == 3) begin
         n = $urandom_range(1, 6);
         repeat (n) bytes.push_back(8'($urandom));
      end
      c = 16'hFFFF;
      foreach (bytes[i]) c = crc_step(c, bytes[i]);
      bytes.push_back(c[7:0]);
      bytes.push_back(c[15:8]);
      if (mode == 1) bytes[$urandom_range(0, bytes.size() - 1)] ^= 8'h01 << $urandom_range(0, 7);
      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            $display("%0t unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            want = pending_q.pop_front();
            if (rsp_data.reg_index !== want.reg_index)
               $display("%0t reg_index exp %0d got %0d", $time, want.reg_index,
                        rsp_data.reg_index);
            if (rsp_data.reg_value !== want.reg_value)
               $display("%0t reg_value exp %h got %h", $time, want.reg_value,
                        rsp_data.reg_value);
            if (rsp_data.data_valid !== want.data_valid)
               $display("%0t data_valid exp %b got %b", $time, want.data_valid,
                        rsp_data.data_valid);
            if (rsp_data.run_last !== want.run_last)
               $display("%0t run_last exp %b got %b", $time, want.run_last,
                        rsp_data.run_last);
            if (rsp_data !== want) errors++;
         end
      end
   end

   // receiver stalls
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         n = $urandom_range(0, 9);
         if (n < 6) rsp_ready <= 1'b1;
         else if (n < 9) rsp_ready <= 1'b0;
         else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end
      end
   end

   task automatic test_defaults();
      send_frame(0, 16'h0000, 1'b1);
      wait_drain();
   endtask

   task automatic test_divisors();
      write_csr(CSR_STEAM_DIV, 16'h7FFF);
      write_csr(CSR_WATER_DIV, 16'd7);
      write_csr(CSR_DEV_TYPE, 16'd1);
      write_csr(CSR_NO_DATA, 16'h7FFF);
      send_frame(0, 16'd3, 1'b1);
      send_frame(1, 16'd0, 1'b0);
      wait_drain();
      write_csr(CSR_STEAM_DIV, 16'd0);
      write_csr(CSR_WATER_DIV, 16'd0);
      write_csr(CSR_DEV_TYPE, 16'd255);
      write_csr(CSR_NO_DATA, 16'h0000);
      send_frame(0, 16'd0, 1'b0);
      wait_drain();
   endtask

   task automatic test_lone_last();
      // single-byte and two-byte frames
      send_byte(8'($urandom), 1'b1);
      send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
      wait_drain();
   endtask

   task automatic test_length();
      send_frame(2, 16'd0, 1'b0);
      send_frame(3, 16'd0, 1'b0);
      wait_drain();
   endtask

   initial begin
      errors = 0;
      byte_total = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_STEAM_DIV;
      csr_wr_data = '0;
      steam_div_q = 15'd1; water_div_q = 15'd1; dev_type_q = 8'd1; no_data_q = 16'h8000;
      crc_q = 16'hFFFF; tail_q = 0; count_q = 0; hold_q = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_defaults();
      test_divisors();
      test_lone_last();
      test_length();
      wait_drain();
      if (errors == 0 && pending_q.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
design/mrfd_pkg.sv
design/mrfd_ram.sv
design/mrfd_div.sv
design/modbus_register_frame_decoder_unit.sv
tb/testbench.sv
